// ===== hdl/rlrm_pkg.sv =====
// Shared types, constants and helper functions for the RLE row morph rasterizer.
package rlrm_pkg;

  localparam int RUN_W     = 8;   // run length and endpoint width
  localparam int POS_W     = 10;  // pixel position, up to four full runs
  localparam int CNT_W     = 7;   // byte count, up to the result cap
  localparam int WEIGHT_W  = 9;   // blend weight, 0..256
  localparam int ACC_W     = WEIGHT_W + RUN_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int RESULT_CAP = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 2'd1;

  localparam logic [6:0]          STRIDE_RESET = 7'd32;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;

  typedef struct packed {
    logic [7:0] start_black0;
    logic [7:0] start_white0;
    logic [7:0] start_black1;
    logic [7:0] start_white1;
    logic [7:0] end_black0;
    logic [7:0] end_white0;
    logic [7:0] end_black1;
    logic [7:0] end_white1;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_last;
  } out_item_t;

  // Four 8-bit values; element 0 is the first black run or endpoint.
  typedef logic [3:0][RUN_W-1:0] quad_t;

  // Pixel boundaries of the drawn row: white spans are [c1,c2) and [c3,c4).
  typedef struct packed {
    logic [POS_W-1:0] c1;
    logic [POS_W-1:0] c2;
    logic [POS_W-1:0] c3;
    logic [POS_W-1:0] c4;
  } bounds_t;

  // Runs to segment endpoints; a zero last run folds the second segment
  // onto the first. All sums wrap at 8 bits.
  function automatic quad_t ends_from_runs(quad_t r);
    quad_t e;
    e[0] = r[0];
    e[1] = r[0] + r[1];
    if (r[3] != '0) begin
      e[2] = e[1] + r[2];
      e[3] = e[2] + r[3];
    end else begin
      e[2] = e[0];
      e[3] = e[1];
    end
    return e;
  endfunction

  // Endpoints back to runs; a second segment that does not start after the first one ends merges into one run.
  function automatic quad_t runs_from_ends(quad_t e);
    quad_t r;
    r[0] = e[0];
    if (e[2] > e[1]) begin
      r[1] = e[1] - e[0];
      r[2] = e[2] - e[1];
      r[3] = e[3] - e[2];
    end else begin
      r[1] = e[3] - e[0];
      r[2] = '0;
      r[3] = '0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/rlrm_mac.sv =====
// Shared multiply-accumulate unit used for the endpoint blend.
module rlrm_mac (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         clear,
  input  logic [rlrm_pkg::WEIGHT_W-1:0] weight,
  input  logic [rlrm_pkg::RUN_W-1:0]    data,
  output logic [rlrm_pkg::ACC_W-1:0]    sum
);

  logic [rlrm_pkg::ACC_W-1:0] acc;
  logic [rlrm_pkg::ACC_W-1:0] product;

  assign product = weight * data;
  assign sum     = (clear ? '0 : acc) + product;

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= sum;
    end
  end

endmodule

// ===== hdl/rlrm_byte_gen.sv =====
// Builds one output byte of pixels from the row's white span boundaries.
module rlrm_byte_gen (
  input  rlrm_pkg::bounds_t bounds,
  input  logic [5:0]        byte_idx,
  output logic [7:0]        pixels
);

  always_comb begin
    logic [rlrm_pkg::POS_W-1:0] pos;
    pixels = '0;
    for (int j = 0; j < 8; j++) begin
      pos = {1'b0, byte_idx, 3'(j)};
      // First pixel of the byte lands in the most significant bit.
      pixels[7-j] = ((pos >= bounds.c1) && (pos < bounds.c2)) ||
                    ((pos >= bounds.c3) && (pos < bounds.c4));
    end
  end

endmodule

// ===== hdl/rle_row_morph_rasterizer.sv =====
// Top level of the RLE row morph rasterizer: sequencer, registers and output stage.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    rlrm_pkg::in_item_t (two four-run rows)
//   out      output     out_valid/out_ready  rlrm_pkg::out_item_t (pixel byte, row_last)
//   cfg      input      cfg_we               cfg_index, cfg_wdata (write only)
//
// An item is loaded, passes the shared multiply-accumulate unit for the
// blend (two products per endpoint), then its runs and byte count are formed;
// the output bytes follow, a new one whenever the output register is free,
// and the block returns to idle. The byte total is at most min(MAX_STRIDE_BYTES, 64).
// Reset is synchronous and active high; it sets blend_factor to 0 and
// line_stride to 32 and empties the output register.
// A stall on the output holds the result register and the byte counter; the
// input is not ready until the last byte of the scanline has been transferred.
module rle_row_morph_rasterizer #(
  parameter int MAX_STRIDE_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rlrm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rlrm_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [rlrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlrm_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  // The result count never exceeds the smaller of the stride limit and the cap.
  localparam int LIMIT = (MAX_STRIDE_BYTES < rlrm_pkg::RESULT_CAP) ?
                         MAX_STRIDE_BYTES : rlrm_pkg::RESULT_CAP;
  localparam logic [rlrm_pkg::CNT_W-1:0] LIMIT_V = rlrm_pkg::CNT_W'(LIMIT);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_RUNS = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                    state;
  logic [2:0]                    step;
  rlrm_pkg::in_item_t            item;
  logic [7:0]                    blend;
  logic [6:0]                    stride;
  rlrm_pkg::quad_t               eb;
  rlrm_pkg::bounds_t             bounds;
  logic [rlrm_pkg::CNT_W-1:0]    total;
  logic [rlrm_pkg::CNT_W-1:0]    k;

  rlrm_pkg::quad_t               es;
  rlrm_pkg::quad_t               ef;
  rlrm_pkg::quad_t               runs;
  rlrm_pkg::bounds_t             bounds_next;
  logic [rlrm_pkg::CNT_W-1:0]    total_next;
  logic [10:0]                   pix_round;
  logic [7:0]                    nbytes;
  logic [6:0]                    stride_sat;
  logic [7:0]                    total_wide;

  logic [rlrm_pkg::WEIGHT_W-1:0] mac_weight;
  logic [rlrm_pkg::RUN_W-1:0]    mac_data;
  logic [rlrm_pkg::ACC_W-1:0]    mac_sum;
  logic [7:0]                    byte_pixels;
  logic                          out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Segment endpoints of both glyph rows, taken from the captured item.
  assign es = rlrm_pkg::ends_from_runs({item.start_white1, item.start_black1,
                                        item.start_white0, item.start_black0});
  assign ef = rlrm_pkg::ends_from_runs({item.end_white1, item.end_black1,
                                        item.end_white0, item.end_black0});

  // Even steps form (256 - b) * start, odd steps add b * end for the same
  // endpoint; bits 15:8 of the sum are the truncated blend.
  assign mac_weight = step[0] ? {1'b0, blend} : (rlrm_pkg::WEIGHT_ONE - {1'b0, blend});
  assign mac_data   = step[0] ? ef[step[2:1]] : es[step[2:1]];

  rlrm_mac u_mac (
    .clk    (clk),
    .en     (state == S_MAC),
    .clear  (!step[0]),
    .weight (mac_weight),
    .data   (mac_data),
    .sum    (mac_sum)
  );

  // Blended runs become absolute pixel boundaries; positions do not wrap.
  always_comb begin
    runs           = rlrm_pkg::runs_from_ends(eb);
    bounds_next.c1 = rlrm_pkg::POS_W'(runs[0]);
    bounds_next.c2 = bounds_next.c1 + rlrm_pkg::POS_W'(runs[1]);
    bounds_next.c3 = bounds_next.c2 + rlrm_pkg::POS_W'(runs[2]);
    bounds_next.c4 = bounds_next.c3 + rlrm_pkg::POS_W'(runs[3]);
    pix_round      = 11'(bounds_next.c4) + 11'd7;
    nbytes         = pix_round[10:3];
    stride_sat     = (stride > LIMIT_V) ? LIMIT_V : stride;
    total_wide     = (nbytes > {1'b0, stride_sat}) ? nbytes : {1'b0, stride_sat};
    total_next     = (total_wide > {1'b0, LIMIT_V}) ? LIMIT_V : total_wide[6:0];
  end

  rlrm_byte_gen u_byte_gen (
    .bounds   (bounds),
    .byte_idx (k[5:0]),
    .pixels   (byte_pixels)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      blend  <= '0;
      stride <= rlrm_pkg::STRIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlrm_pkg::REG_BLEND_FACTOR: blend  <= cfg_wdata;
        rlrm_pkg::REG_LINE_STRIDE:  stride <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
      k         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            step  <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (step[0]) begin
            eb[step[2:1]] <= mac_sum[15:8];
          end
          step <= step + 3'd1;
          if (step == 3'd7) begin
            state <= S_RUNS;
          end
        end
        S_RUNS: begin
          bounds <= bounds_next;
          total  <= total_next;
          k      <= '0;
          // An empty row with no padding produces no transfer at all.
          state  <= (total_next == '0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (k != total) begin
              out_valid           <= 1'b1;
              out_data.pixel_byte <= byte_pixels;
              out_data.row_last   <= (k + 7'd1 == total);
              k                   <= k + 7'd1;
            end else begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The output register is always empty when a new item may be taken.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !out_valid)
    else $error("output holds a byte while the block is idle");

  // The transfer of the last byte returns the block to idle.
  a_last_ends_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.row_last) |=> (state == S_IDLE))
    else $error("block did not finish the scanline after its last byte");

  // The byte counter never runs past the scanline's byte total.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ((k <= total) && (total <= LIMIT_V)))
    else $error("byte counter beyond scanline total");

  // An accepted item always starts the blend sequence from its first step.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> ((state == S_MAC) && (step == 3'd0)))
    else $error("accepted item did not start the blend");

endmodule

// ===== dv/rle_row_morph_rasterizer_tb.sv =====
// Self-checking testbench for the RLE row morph rasterizer, with a built-in scanline predictor.
module rle_row_morph_rasterizer_tb;

  // The block never emits more than this many bytes for one scanline.
  localparam int BYTE_LIMIT = 64;
  // Cycles allowed after the last expected byte before the block counts as idle.
  // It is long enough to cover a row that yields no bytes at all and is still
  // being worked on.
  localparam int SETTLE_CYCLES = 90;
  localparam int MAX_REPORTS = 10;

  typedef logic [3:0][7:0] run_quad_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  rlrm_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rlrm_pkg::out_item_t  out_data;
  logic                 cfg_we = 1'b0;
  logic [rlrm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rlrm_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

  // Our copy of the configuration registers, at their reset values.
  logic [7:0] blend_cfg  = 8'd0;
  logic [6:0] stride_cfg = rlrm_pkg::STRIDE_RESET;

  // Bytes that the block still owes us, oldest first.
  rlrm_pkg::out_item_t expected_bytes[$];
  int mismatch_count = 0;

  // Idle rates in percent of cycles for the input and output side.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  rle_row_morph_rasterizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Segment endpoints of one four-run row. A zero last white run means the
  // row holds only its first white segment, so the second one is folded onto it.
  function automatic run_quad_t segment_ends(run_quad_t r);
    run_quad_t e;
    e[0] = r[0];
    e[1] = r[0] + r[1];
    if (r[3] != 8'd0) begin
      e[2] = e[1] + r[2];
      e[3] = e[2] + r[3];
    end else begin
      e[2] = e[0];
      e[3] = e[1];
    end
    return e;
  endfunction

  // Works out every byte the block must emit for one scanline and queues it.
  function automatic void predict_scanline(rlrm_pkg::in_item_t it);
    run_quad_t           rs, rf, es, ef, eb, runs;
    logic [7:0]          row_bytes [0:127];
    logic [7:0]          cur, mask;
    int unsigned         wt, nbytes, stride, total;
    rlrm_pkg::out_item_t o;
    rs = {it.start_white1, it.start_black1, it.start_white0, it.start_black0};
    rf = {it.end_white1, it.end_black1, it.end_white0, it.end_black0};
    es = segment_ends(rs);
    ef = segment_ends(rf);
    wt = blend_cfg;
    for (int i = 0; i < 4; i++) begin
      eb[i] = 8'(((256 - wt) * es[i] + wt * ef[i]) / 256);
    end
    // Back to runs. When blending collapses the second segment, everything
    // between the first start and the last end becomes one white run.
    runs[0] = eb[0];
    if (eb[2] > eb[1]) begin
      runs[1] = eb[1] - eb[0];
      runs[2] = eb[2] - eb[1];
      runs[3] = eb[3] - eb[2];
    end else begin
      runs[1] = eb[3] - eb[0];
      runs[2] = 8'd0;
      runs[3] = 8'd0;
    end
    // Draw the pixels MSB first; odd runs are white.
    nbytes = 0;
    cur = 8'h00;
    mask = 8'h80;
    for (int i = 0; i < 4; i++) begin
      for (int p = 0; p < int'(runs[i]); p++) begin
        if (i % 2 == 1) cur = cur | mask;
        mask = mask >> 1;
        if (mask == 8'h00) begin
          row_bytes[nbytes] = cur;
          nbytes++;
          cur = 8'h00;
          mask = 8'h80;
        end
      end
    end
    if (mask != 8'h80) begin
      row_bytes[nbytes] = cur;
      nbytes++;
    end
    // Pad to the stride, never past the byte limit; long rows are cut off.
    stride = (stride_cfg > BYTE_LIMIT) ? BYTE_LIMIT : stride_cfg;
    total = (nbytes > stride) ? nbytes : stride;
    if (total > BYTE_LIMIT) total = BYTE_LIMIT;
    for (int unsigned k = 0; k < total; k++) begin
      o.pixel_byte = (k < nbytes) ? row_bytes[k] : 8'h00;
      o.row_last   = (k + 1 == total);
      expected_bytes.push_back(o);
    end
  endfunction

  function automatic rlrm_pkg::in_item_t make_scanline(run_quad_t s, run_quad_t f);
    rlrm_pkg::in_item_t it;
    it.start_black0 = s[0];
    it.start_white0 = s[1];
    it.start_black1 = s[2];
    it.start_white1 = s[3];
    it.end_black0   = f[0];
    it.end_white0   = f[1];
    it.end_black1   = f[2];
    it.end_white1   = f[3];
    return it;
  endfunction

  // Random scanline. Half are ordinary two-segment rows; the rest are short
  // runs, single-segment rows and rows made of the extreme run values.
  function automatic rlrm_pkg::in_item_t random_scanline();
    run_quad_t s, f;
    int sel;
    sel = $urandom_range(9);
    for (int i = 0; i < 4; i++) begin
      case (sel)
        5, 6: begin
          s[i] = 8'($urandom_range(12));
          f[i] = 8'($urandom_range(12));
        end
        9: begin
          s[i] = $urandom_range(1) ? 8'hFF : 8'h00;
          f[i] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        default: begin
          s[i] = 8'($urandom);
          f[i] = 8'($urandom);
        end
      endcase
    end
    if (sel == 7 || sel == 8) begin
      s[3] = 8'd0;
      if ($urandom_range(1)) f[3] = 8'd0;
    end
    return make_scanline(s, f);
  endfunction

  // Sends one scanline. Called at a rising edge; returns at the edge where the
  // transfer happened, with in_valid still high so a following call can keep
  // it high without a drop in between.
  task automatic send_scanline(rlrm_pkg::in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_scanline(it);
  endtask

  // Drops in_valid, waits until every owed byte has come out and lets the
  // block finish any row that yields no bytes.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers on back-to-back cycles. Only called while idle.
  task automatic program_config(logic [7:0] blend, logic [6:0] stride);
    cfg_we    <= 1'b1;
    cfg_index <= rlrm_pkg::REG_BLEND_FACTOR;
    cfg_wdata <= blend;
    @(posedge clk);
    cfg_index <= rlrm_pkg::REG_LINE_STRIDE;
    cfg_wdata <= {1'b0, stride};
    @(posedge clk);
    cfg_we <= 1'b0;
    blend_cfg  = blend;
    stride_cfg = stride;
  endtask

  // Scanlines under the reset configuration: start glyph only, 32-byte stride.
  task automatic test_reset_defaults();
    send_scanline(make_scanline({8'd9, 8'd7, 8'd5, 8'd3}, {8'd40, 8'd30, 8'd20, 8'd10}));
    send_scanline(make_scanline({8'd0, 8'd0, 8'd8, 8'd0}, {8'd1, 8'd2, 8'd3, 8'd4}));
    quiesce();
  endtask

  // The blend factor at its maximum of 255 and at half.
  task automatic test_blend_extremes();
    rlrm_pkg::in_item_t it;
    it = make_scanline({8'd4, 8'd4, 8'd4, 8'd4}, {8'd16, 8'd16, 8'd16, 8'd16});
    program_config(8'd255, 7'd16);
    send_scanline(it);
    quiesce();
    program_config(8'd128, 7'd16);
    send_scanline(it);
    send_scanline(make_scanline({8'd30, 8'd3, 8'd10, 8'd20}, {8'd3, 8'd40, 8'd2, 8'd1}));
    quiesce();
  endtask

  // Single-segment rows, a second segment that collapses in the blend, and
  // endpoint sums that wrap past 255.
  task automatic test_folded_rows();
    program_config(8'd128, 7'd8);
    send_scanline(make_scanline({8'd0, 8'd12, 8'd5, 8'd10}, {8'd0, 8'd20, 8'd7, 8'd0}));
    send_scanline(make_scanline({8'd0, 8'd50, 8'd5, 8'd10}, {8'd60, 8'd1, 8'd1, 8'd1}));
    send_scanline(make_scanline({8'd10, 8'd50, 8'd100, 8'd200}, {8'd40, 8'd30, 8'd20, 8'd0}));
    quiesce();
  endtask

  // Every run at zero, every run at 255, and the two mixed.
  task automatic test_run_extremes();
    program_config(8'd0, 7'd32);
    send_scanline(make_scanline('0, '0));
    send_scanline(make_scanline('1, '1));
    send_scanline(make_scanline({8'h00, 8'hFF, 8'h00, 8'hFF}, {8'hFF, 8'h00, 8'hFF, 8'h00}));
    quiesce();
  endtask

  // Rows longer than the byte limit get cut, strides past the limit saturate.
  task automatic test_byte_limit();
    rlrm_pkg::in_item_t long_row;
    // Endpoints 10, 5, 200, 100 give runs 10, 251, 195, 156: 77 bytes.
    long_row = make_scanline({8'd156, 8'd195, 8'd251, 8'd10}, '0);
    program_config(8'd0, 7'd64);
    send_scanline(long_row);
    quiesce();
    program_config(8'd0, 7'd127);
    send_scanline(long_row);
    send_scanline(make_scanline({8'd1, 8'd1, 8'd1, 8'd1}, '0));
    quiesce();
  endtask

  // Stride 0 adds no padding, so an empty row yields nothing at all; stride 1
  // leaves short rows with only their own bytes.
  task automatic test_stride_corners();
    program_config(8'd0, 7'd0);
    send_scanline(make_scanline('0, '0));
    send_scanline(make_scanline({8'd0, 8'd0, 8'd2, 8'd1}, '0));
    quiesce();
    program_config(8'd0, 7'd1);
    send_scanline(make_scanline({8'd0, 8'd0, 8'd4, 8'd4}, '0));
    send_scanline(make_scanline({8'd0, 8'd0, 8'd8, 8'd8}, '0));
    quiesce();
  endtask

  // Random scanlines with the configuration changed every twenty transfers.
  task automatic test_random_traffic(int n_items);
    logic [7:0] blend;
    logic [6:0] stride;
    for (int n = 0; n < n_items; n++) begin
      if (n % 20 == 0) begin
        quiesce();
        case ($urandom_range(3))
          0:       blend = 8'd0;
          1:       blend = 8'd255;
          default: blend = 8'($urandom);
        endcase
        case ($urandom_range(7))
          0:       stride = 7'd0;
          1:       stride = 7'd64;
          2:       stride = 7'($urandom);
          default: stride = 7'($urandom_range(40, 1));
        endcase
        program_config(blend, stride);
      end
      send_scanline(random_scanline());
    end
    quiesce();
  endtask

  // Output side: out_ready is redrawn every cycle from the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every output transfer is checked against the oldest owed byte.
  always @(posedge clk) begin
    rlrm_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected byte %h row_last %b", $realtime,
                   out_data.pixel_byte, out_data.row_last);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.pixel_byte !== want.pixel_byte || out_data.row_last !== want.row_last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: byte expected %h/%b got %h/%b", $realtime, want.pixel_byte,
                     want.row_last, out_data.pixel_byte, out_data.row_last);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with both sides idling.
    send_idle_pct = 30;
    recv_idle_pct = 68;
    test_reset_defaults();
    test_blend_extremes();
    test_folded_rows();
    test_run_extremes();
    test_byte_limit();
    test_stride_corners();

    // Random part: sender idles little and receiver a lot, then the reverse,
    // then full speed on both sides.
    test_random_traffic(100);
    send_idle_pct = 68;
    recv_idle_pct = 30;
    test_random_traffic(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(110);

    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("rle_row_morph_rasterizer_tb: clean");
    end else begin
      $display("rle_row_morph_rasterizer_tb: errors");
    end
    $finish;
  end

  // A hung handshake ends the run here, well past the slowest correct run.
  initial begin
    #3000000;
    $display("rle_row_morph_rasterizer_tb: errors");
    $finish;
  end

endmodule

// ===== rle_row_morph_rasterizer.f =====
hdl/rlrm_pkg.sv
hdl/rlrm_mac.sv
hdl/rlrm_byte_gen.sv
hdl/rle_row_morph_rasterizer.sv
dv/rle_row_morph_rasterizer_tb.sv
